// ===== rtl/core/fbfl_pkg.sv =====
`default_nettype none

package fbfl_pkg;

	// Pool geometry.
	localparam int NUM_BLOCKS = 256;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int LINK_W     = IDX_W + 1;
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

	// Configuration field widths.
	localparam int SIZE_W  = 16;
	localparam int ALIGN_W = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ALIGN = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 16'd64;
	localparam logic [ALIGN_W-1:0] BLOCK_ALIGN_RST = 13'd16;

	// Item actions.
	localparam logic ACT_ACQUIRE = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED   = 2'd1;
	localparam logic [1:0] ST_TOO_LARGE   = 2'd2;
	localparam logic [1:0] ST_BAD_RELEASE = 2'd3;

	// Write request into the link memory.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [LINK_W-1:0] data;
	} link_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/fbfl_link_ram.sv =====
`default_nettype none

module fbfl_link_ram (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [fbfl_pkg::IDX_W-1:0]    rd_addr,
	output logic      [fbfl_pkg::LINK_W-1:0]   rd_link,
	input  wire fbfl_pkg::link_wr_t            wr
);

	logic [fbfl_pkg::LINK_W-1:0] mem [fbfl_pkg::NUM_BLOCKS];
	logic [fbfl_pkg::NUM_BLOCKS-1:0] written_q;
	logic [fbfl_pkg::LINK_W-1:0] rd_data_q;
	logic                        rd_written_q;
	logic [fbfl_pkg::IDX_W-1:0]  rd_addr_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
		rd_addr_q <= rd_addr;
	end

	// An entry never written since reset holds its initial link, index plus one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			rd_written_q <= written_q[rd_addr];
		end
	end

	assign rd_link = rd_written_q ? rd_data_q
		: ({1'b0, rd_addr_q} + fbfl_pkg::LINK_W'(1));

endmodule

`default_nettype wire

// ===== rtl/core/fbfl_ctrl.sv =====
`default_nettype none

module fbfl_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              action,
	input  wire logic [fbfl_pkg::IDX_W-1:0]        block_index,
	input  wire logic [fbfl_pkg::SIZE_W-1:0]       request_size,
	input  wire logic [fbfl_pkg::ALIGN_W-1:0]      request_alignment,
	input  wire logic [fbfl_pkg::SIZE_W-1:0]       block_size,
	input  wire logic [fbfl_pkg::ALIGN_W-1:0]      block_alignment,
	output logic                                   done,
	output logic [1:0]                             status,
	output logic [fbfl_pkg::IDX_W-1:0]             granted_index,
	output logic [fbfl_pkg::CNT_W-1:0]             free_count,
	output logic [fbfl_pkg::IDX_W-1:0]             link_rd_addr,
	input  wire logic [fbfl_pkg::LINK_W-1:0]       link_rd_data,
	output fbfl_pkg::link_wr_t                     link_wr
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic                           action_q;
	logic [fbfl_pkg::IDX_W-1:0]     index_q;
	logic [fbfl_pkg::SIZE_W-1:0]    size_q;
	logic [fbfl_pkg::ALIGN_W-1:0]   align_q;
	logic [fbfl_pkg::LINK_W-1:0]    head_q;
	logic [fbfl_pkg::CNT_W-1:0]     count_q;

	logic                           accept;
	logic                           too_large;
	logic                           exhausted;
	logic                           bad_release;
	logic                           pop_ok;
	logic                           push_ok;
	logic [1:0]                     status_d;
	logic [fbfl_pkg::CNT_W-1:0]     count_d;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q == S_EXEC);

	// The memory reads the head's successor every cycle; the read taken at
	// the accept edge is the one the execute cycle uses.
	assign link_rd_addr = head_q[fbfl_pkg::IDX_W-1:0];

	assign too_large = (size_q > block_size) || (align_q > block_alignment);
	assign exhausted = (count_q == '0)
		|| (head_q >= fbfl_pkg::LINK_W'(fbfl_pkg::NUM_BLOCKS));
	assign bad_release = ({1'b0, index_q} >= fbfl_pkg::LINK_W'(fbfl_pkg::NUM_BLOCKS))
		|| (count_q >= fbfl_pkg::CNT_W'(fbfl_pkg::NUM_BLOCKS));

	assign pop_ok  = busy && (action_q == fbfl_pkg::ACT_ACQUIRE) && !too_large && !exhausted;
	assign push_ok = busy && (action_q == fbfl_pkg::ACT_RELEASE) && !bad_release;

	always_comb begin
		count_d = count_q;
		if (action_q == fbfl_pkg::ACT_ACQUIRE) begin
			if (too_large) begin
				status_d = fbfl_pkg::ST_TOO_LARGE;
			end else if (exhausted) begin
				status_d = fbfl_pkg::ST_EXHAUSTED;
			end else begin
				status_d = fbfl_pkg::ST_OK;
				count_d  = count_q - fbfl_pkg::CNT_W'(1);
			end
		end else begin
			if (bad_release) begin
				status_d = fbfl_pkg::ST_BAD_RELEASE;
			end else begin
				status_d = fbfl_pkg::ST_OK;
				count_d  = count_q + fbfl_pkg::CNT_W'(1);
			end
		end
	end

	assign link_wr.en   = push_ok;
	assign link_wr.addr = index_q;
	assign link_wr.data = head_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			index_q  <= block_index;
			size_q   <= request_size;
			align_q  <= request_alignment;
		end
		if (busy) begin
			status        <= status_d;
			granted_index <= pop_ok ? head_q[fbfl_pkg::IDX_W-1:0] : '0;
			free_count    <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= fbfl_pkg::CNT_W'(fbfl_pkg::NUM_BLOCKS);
			done    <= 1'b0;
		end else begin
			done <= busy;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					if (pop_ok) begin
						head_q <= link_rd_data;
					end else if (push_ok) begin
						head_q <= {1'b0, index_q};
					end
					count_q <= count_d;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/fixed_block_free_list_pool.sv =====
`default_nettype none

// Fixed-size block free-list pool. Blocks are named by index and kept on a
// linked free list whose links live in a synchronous memory. An item is taken
// when start is high and busy is low; busy then stays high while the item
// executes, and in the following cycle done pulses for one cycle with
// status, granted_index and free_count. Every item yields exactly one result,
// and the receiver has no way to hold it off, so it must capture the result in
// the cycle done is high. A new item may be started in that same cycle, but no
// item is taken while another one executes, and that limit is set by the
// link memory: popping a block needs the successor of the head, which is read
// from memory at the accept edge and arrives in the execute cycle. An acquire
// whose size or alignment exceeds the configured limits reports status 2; an
// acquire on an empty list reports status 1; a release of an index outside the
// pool, or while every block is already free, reports status 3. A failed item
// changes no state. granted_index is zero on everything but a successful
// acquire. Configuration writes (index 0 block size, index 1 block alignment)
// are always ready and must only be issued while no item is in flight. After
// reset the pool is immediately usable, with every block free in index order.
module fixed_block_free_list_pool (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic                                  action,
	input  wire logic [fbfl_pkg::IDX_W-1:0]            block_index,
	input  wire logic [fbfl_pkg::SIZE_W-1:0]           request_size,
	input  wire logic [fbfl_pkg::ALIGN_W-1:0]          request_alignment,
	output logic                                       done,
	output logic [1:0]                                 status,
	output logic [fbfl_pkg::IDX_W-1:0]                 granted_index,
	output logic [fbfl_pkg::CNT_W-1:0]                 free_count,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [fbfl_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic [fbfl_pkg::SIZE_W-1:0]  block_size_q;
	logic [fbfl_pkg::ALIGN_W-1:0] block_align_q;

	logic [fbfl_pkg::IDX_W-1:0]   link_rd_addr;
	logic [fbfl_pkg::LINK_W-1:0]  link_rd_data;
	fbfl_pkg::link_wr_t           link_wr;

	// The register file takes a write on any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= fbfl_pkg::BLOCK_SIZE_RST;
			block_align_q <= fbfl_pkg::BLOCK_ALIGN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fbfl_pkg::CFG_BLOCK_SIZE: begin
					block_size_q <= cfg_data;
				end
				fbfl_pkg::CFG_BLOCK_ALIGN: begin
					block_align_q <= cfg_data[fbfl_pkg::ALIGN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer: holds the head and free count, runs the checks and issues
	// the link memory's read and write.
	fbfl_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.action            (action),
		.block_index       (block_index),
		.request_size      (request_size),
		.request_alignment (request_alignment),
		.block_size        (block_size_q),
		.block_alignment   (block_align_q),
		.done              (done),
		.status            (status),
		.granted_index     (granted_index),
		.free_count        (free_count),
		.link_rd_addr      (link_rd_addr),
		.link_rd_data      (link_rd_data),
		.link_wr           (link_wr)
	);

	// Link memory: one successor per block, with per-entry written flags so
	// that an untouched entry reads as its initial successor.
	fbfl_link_ram u_link_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (link_rd_addr),
		.rd_link (link_rd_data),
		.wr      (link_wr)
	);

endmodule

`default_nettype wire

// ===== rtl/core/fbfl_checker.sv =====
`default_nettype none

module fbfl_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic                              done,
	input wire logic [1:0]                        status,
	input wire logic [fbfl_pkg::IDX_W-1:0]        granted_index,
	input wire logic [fbfl_pkg::CNT_W-1:0]        free_count
);

	// An accepted item executes in the next cycle and reports in the one after.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy ##1 done)
	else $error("accepted item did not execute and report on schedule");

	// A result only follows an execute cycle, and the block is free again.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
	else $error("result beat without a preceding execute cycle");

	// Only a successful item names a block.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != fbfl_pkg::ST_OK) |-> (granted_index == '0))
	else $error("failed item reported a granted block");

	// The free count never exceeds the pool.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (free_count <= fbfl_pkg::CNT_W'(fbfl_pkg::NUM_BLOCKS)))
	else $error("free count above pool size");

endmodule

bind fixed_block_free_list_pool fbfl_checker u_fbfl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.granted_index (granted_index),
	.free_count    (free_count)
);

`default_nettype wire

// ===== tb/sv/fixed_block_free_list_pool_tb.sv =====
`default_nettype none

module fixed_block_free_list_pool_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import fbfl_pkg::*;

	// The run is ended if this many cycles in a row pass without a beat on any
	// channel. The slowest legal stretch is a sender gap or a drain pause, far
	// shorter than the limit, so this is a generous margin.
	localparam int WATCHDOG_LIMIT = 2000;

	// One result beat as the block reports it.
	typedef struct {
		logic [1:0]       status;
		logic [IDX_W-1:0] granted;
		logic [CNT_W-1:0] count;
	} pool_result_t;

	logic clk;
	logic arst_n = 1'b0;

	// Every input of the block starts at a known value.
	logic                  start             = 1'b0;
	logic                  action            = ACT_ACQUIRE;
	logic [IDX_W-1:0]      block_index       = '0;
	logic [SIZE_W-1:0]     request_size      = '0;
	logic [ALIGN_W-1:0]    request_alignment = '0;
	logic                  cfg_valid         = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index         = CFG_BLOCK_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data          = '0;

	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [IDX_W-1:0]   granted_index;
	logic [CNT_W-1:0]   free_count;
	logic               cfg_ready;

	fixed_block_free_list_pool dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.action            (action),
		.block_index       (block_index),
		.request_size      (request_size),
		.request_alignment (request_alignment),
		.done              (done),
		.status            (status),
		.granted_index     (granted_index),
		.free_count        (free_count),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	// Our own copy of the pool: the link store, the head of the free list,
	// the number of free blocks and the two limit registers.
	logic [LINK_W-1:0]  link_mem [NUM_BLOCKS];
	int unsigned        head_ptr;
	int unsigned        free_total;
	logic [SIZE_W-1:0]  size_limit;
	logic [ALIGN_W-1:0] align_limit;

	// Results that accepted items still owe us, oldest first.
	pool_result_t pending_results [$];
	// Blocks the stimulus believes it holds; used to build sensible releases.
	int unsigned  held_blocks [$];

	int errors = 0;
	int idle_cycles = 0;
	// Sender pacing: beats left in the current burst, and whether start is
	// currently scheduled high (start itself lags by one NBA).
	int burst_left = 0;
	bit start_high = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Reset image of the pool: every block free, linked in index order, with
	// the last block pointing at the null value NUM_BLOCKS.
	task automatic reset_pool_copy();
		for (int i = 0; i < NUM_BLOCKS; i++)
			link_mem[IDX_W'(i)] = LINK_W'(i + 1);
		head_ptr = 0;
		free_total = NUM_BLOCKS;
		size_limit = BLOCK_SIZE_RST;
		align_limit = BLOCK_ALIGN_RST;
	endtask

	// Applies one item to our copy of the pool and returns the result the
	// block has to report for it. Limit checks take priority over the empty
	// check, and a refused item leaves the pool untouched.
	function automatic pool_result_t apply_pool_item(logic act, logic [IDX_W-1:0] idx,
			logic [SIZE_W-1:0] size, logic [ALIGN_W-1:0] align);
		pool_result_t r;
		r.status = ST_OK;
		r.granted = '0;
		if (act == ACT_ACQUIRE) begin
			if (size > size_limit || align > align_limit) begin
				r.status = ST_TOO_LARGE;
			end else if (free_total == 0 || head_ptr >= NUM_BLOCKS) begin
				r.status = ST_EXHAUSTED;
			end else begin
				r.granted = head_ptr[IDX_W-1:0];
				head_ptr = 32'(link_mem[head_ptr[IDX_W-1:0]]);
				free_total--;
			end
		end else begin
			// A release into a full pool is refused. No ownership is tracked,
			// so releasing a block that is already free is otherwise accepted.
			if (32'(idx) >= NUM_BLOCKS || free_total >= NUM_BLOCKS) begin
				r.status = ST_BAD_RELEASE;
			end else begin
				link_mem[idx] = LINK_W'(head_ptr);
				head_ptr = 32'(idx);
				free_total++;
			end
		end
		r.count = free_total[CNT_W-1:0];
		return r;
	endfunction

	// Drops start, at most once per time step.
	task automatic lower_start();
		if (start_high) begin
			start <= 1'b0;
			start_high = 1'b0;
		end
	endtask

	// The sender works in bursts. At the start of each burst it may sit idle
	// for a random gap; a gap of zero keeps items back to back. Now and then a
	// long burst gives a stretch with no idling at all.
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
			                                        : $urandom_range(1, 12);
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				lower_start();
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// Sends one item and records the result it must produce. The item is
	// taken at the first rising edge with start high and busy low; start is
	// left high so that a following item can go out back to back.
	task automatic send_item(logic act, logic [IDX_W-1:0] idx,
			logic [SIZE_W-1:0] size, logic [ALIGN_W-1:0] align);
		pool_result_t r;
		pace_sender();
		start <= 1'b1;
		start_high = 1'b1;
		action <= act;
		block_index <= idx;
		request_size <= size;
		request_alignment <= align;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		r = apply_pool_item(act, idx, size, align);
		pending_results.push_back(r);
		if (act == ACT_ACQUIRE && r.status == ST_OK)
			held_blocks.push_back(32'(r.granted));
	endtask

	// Stops sending and waits until every owed result has arrived.
	task automatic wait_drained();
		lower_start();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Writes one limit register. Writes only go out while the pool is idle.
	task automatic write_limit(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		// Only the low bits of the alignment register exist.
		if (index == CFG_BLOCK_SIZE)
			size_limit = data;
		else
			align_limit = data[ALIGN_W-1:0];
	endtask

	task automatic acquire_block(logic [SIZE_W-1:0] size, logic [ALIGN_W-1:0] align);
		send_item(ACT_ACQUIRE, IDX_W'($urandom_range(0, 255)), size, align);
	endtask

	task automatic release_block(logic [IDX_W-1:0] idx);
		send_item(ACT_RELEASE, idx, SIZE_W'($urandom), ALIGN_W'($urandom_range(0, 8191)));
	endtask

	// One random item. Most items are well formed: acquires that fit the
	// current limits (often exactly at them) and releases of blocks we hold.
	// The rest is noise across the whole field ranges, which also produces
	// oversize requests, refused releases and repeated releases.
	task automatic random_item(int acquire_pct, int noise_pct);
		int pick;
		logic [SIZE_W-1:0]  size;
		logic [ALIGN_W-1:0] align;
		if ($urandom_range(0, 99) < noise_pct) begin
			send_item(($urandom_range(0, 1) == 1) ? ACT_RELEASE : ACT_ACQUIRE,
			          IDX_W'($urandom_range(0, 255)), SIZE_W'($urandom),
			          ALIGN_W'($urandom_range(0, 8191)));
		end else if ($urandom_range(0, 99) < acquire_pct || held_blocks.size() == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				size = size_limit;
				align = align_limit;
			end else begin
				size = SIZE_W'($urandom_range(0, int'(size_limit)));
				align = ALIGN_W'($urandom_range(0, int'(align_limit)));
			end
			acquire_block(size, align);
		end else begin
			pick = $urandom_range(0, held_blocks.size() - 1);
			release_block(IDX_W'(held_blocks[pick]));
			held_blocks.delete(pick);
		end
	endtask

	// Directed checks of the limit logic and the full-pool refusal, first at
	// the reset limits, then at the smallest limits and at the largest block size.
	task automatic test_directed_limits();
		// Nothing is held yet, so any release is refused.
		release_block(8'd0);
		acquire_block(16'd0, 13'd0);
		acquire_block(BLOCK_SIZE_RST, BLOCK_ALIGN_RST);
		acquire_block(BLOCK_SIZE_RST + 16'd1, 13'd0);
		acquire_block(16'd0, BLOCK_ALIGN_RST + 13'd1);
		acquire_block(16'hFFFF, 13'h1FFF);
		release_block(IDX_W'(held_blocks.pop_back()));

		// A block size of zero still serves zero-byte requests.
		write_limit(CFG_BLOCK_SIZE, 16'd0);
		write_limit(CFG_BLOCK_ALIGN, 16'd0);
		acquire_block(16'd0, 13'd0);
		acquire_block(16'd1, 13'd0);
		acquire_block(16'd0, 13'd1);

		// The upper bits of the alignment write fall away, leaving 4096.
		write_limit(CFG_BLOCK_SIZE, 16'hFFFF);
		write_limit(CFG_BLOCK_ALIGN, 16'hF000);
		acquire_block(16'hFFFF, 13'd4096);
		acquire_block(16'd0, 13'd4097);
	endtask

	// Drains the pool well past empty so that exhausted answers show up, then
	// hands every block back and pushes a few releases into the full pool.
	task automatic test_drain_and_refill();
		write_limit(CFG_BLOCK_ALIGN, 16'h1FFF);
		repeat (320) random_item(95, 4);
		repeat (320) random_item(4, 4);
	endtask

	// Random traffic under the small extreme limits and then under random
	// ones. Once in a while the sender holds off until the pool has answered
	// every item, so the block also restarts from an idle state.
	task automatic test_random_settings();
		write_limit(CFG_BLOCK_SIZE, 16'd1);
		write_limit(CFG_BLOCK_ALIGN, 16'd1);
		repeat (250) random_item(55, 10);
		write_limit(CFG_BLOCK_SIZE, 16'd0);
		write_limit(CFG_BLOCK_ALIGN, 16'd0);
		repeat (250) random_item(45, 10);
		repeat (4) begin
			write_limit(CFG_BLOCK_SIZE, CFG_DATA_W'($urandom_range(0, 65535)));
			write_limit(CFG_BLOCK_ALIGN, CFG_DATA_W'($urandom_range(0, 65535)));
			repeat (200) begin
				if ($urandom_range(0, 49) == 0)
					wait_drained();
				random_item(50, 10);
			end
		end
	endtask

	// Releasing a block twice is accepted, which closes the list into a
	// loop. The acquires that follow walk that loop and hand out the same
	// block again; this runs last since the list stays looped from then on.
	task automatic test_repeated_release();
		int unsigned blk;
		write_limit(CFG_BLOCK_SIZE, 16'hFFFF);
		write_limit(CFG_BLOCK_ALIGN, 16'h1FFF);
		acquire_block(16'd0, 13'd0);
		acquire_block(16'd0, 13'd0);
		blk = held_blocks.size() != 0 ? held_blocks[$] : 0;
		release_block(IDX_W'(blk));
		release_block(IDX_W'(blk));
		repeat (4) acquire_block(16'd1, 13'd1);
	endtask

	// Every done pulse is one result beat; it must match the oldest owed
	// result field by field.
	always @(posedge clk) begin
		pool_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no item outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (granted_index !== want.granted) begin
					$error("granted_index: expected %0d, got %0d", want.granted, granted_index);
					errors++;
				end
				if (free_count !== want.count) begin
					$error("free_count: expected %0d, got %0d", want.count, free_count);
					errors++;
				end
			end
		end
	end

	// Watchdog: any beat on the item, result or register channel restarts it.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fixed_block_free_list_pool_tb: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reset_pool_copy();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_limits();
		test_drain_and_refill();
		test_random_settings();
		test_repeated_release();

		// Let the last results come in, then keep watching in case the
		// block sends anything it should not.
		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("fixed_block_free_list_pool_tb: done, clean");
		else
			$display("fixed_block_free_list_pool_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
